>>> sv/eais_pkg.sv
// Shared types and constants for the event angle index search unit.
`timescale 1ns / 1ps

package eais_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = 9;
    localparam int ANGLE_W     = 16;
    localparam int CNT_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISING_ONLY = 1'd1;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   entry_index;
        logic [ANGLE_W-1:0] entry_angle;
        logic [ANGLE_W-1:0] target_angle;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] found_index;
        logic             below_first;
    } t_out_word;

endpackage

>>> sv/event_angle_index_search_unit.sv
// Event angle table with a binary search for the last entry at or below a target angle.
`timescale 1ns / 1ps

// A write word stores one table entry and leaves the unit ready at once. A
// search word runs a binary search through one shared compare unit and the
// table memory; each probe is a memory read (S_PROBE), then a compare (S_CMP),
// after a start from S_IDLE, and S_DONE hands the result to the output
// register. The unit stalls its input until the result is in the output
// register, but a finished result may wait there while the next word is taken.
module event_angle_index_search_unit
    import eais_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_word
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_event_count;
    logic                r_rising_only;
    logic [BOUND_W-1:0]  r_lo, n_lo;
    logic [BOUND_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]   r_mid;
    logic [ANGLE_W-1:0]  r_target;
    logic [ANGLE_W-1:0]  r_rdata;
    t_out_word           r_res, n_res;
    t_out_word           r_out;
    logic                r_out_valid;
    logic [ANGLE_W-1:0]  r_mem [TABLE_DEPTH];

    logic                in_accept;
    logic                out_free;
    logic [BOUND_W-1:0]  eff_count;
    logic [BOUND_W:0]    mid_sum;
    logic [ADDR_W-1:0]   mid;
    logic                le;
    logic [BOUND_W-1:0]  lo_dec;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_word    = r_out;

    always_comb begin
        if (r_event_count == '0) begin
            eff_count = BOUND_W'(1);
        end else if (r_event_count > CNT_W'(TABLE_DEPTH)) begin
            eff_count = BOUND_W'(TABLE_DEPTH);
        end else begin
            eff_count = BOUND_W'(r_event_count);
        end
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} - (BOUND_W + 1)'(1);
    assign mid     = mid_sum[ADDR_W:1];
    assign le      = (r_rdata <= r_target);

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_res   = r_res;
        lo_dec  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && i_word.command == CMD_SEARCH) begin
                    n_lo    = '0;
                    n_hi    = eff_count;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (le) begin
                    n_lo = BOUND_W'(r_mid) + BOUND_W'(1);
                end else begin
                    n_hi = BOUND_W'(r_mid);
                end
                if (n_lo >= n_hi) begin
                    lo_dec = n_lo - BOUND_W'(1);
                    if (n_lo == '0) begin
                        n_res.below_first = 1'b1;
                        n_res.found_index = '0;
                    end else begin
                        n_res.below_first = 1'b0;
                        n_res.found_index = lo_dec[IDX_W-1:0];
                        if (r_rising_only) begin
                            n_res.found_index[0] = 1'b0;
                        end
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_event_count <= CNT_W'(1);
            r_rising_only <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_EVENT_COUNT: r_event_count <= i_cfg_data[CNT_W-1:0];
                    REG_RISING_ONLY: r_rising_only <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_res <= n_res;
        if (r_state == S_PROBE) begin
            r_mid <= mid;
        end
        if (in_accept && i_word.command == CMD_SEARCH) begin
            r_target <= i_word.target_angle;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_word.command == CMD_WRITE) begin
            r_mem[i_word.entry_index[ADDR_W-1:0]] <= i_word.entry_angle;
        end
        r_rdata <= r_mem[mid];
    end

endmodule

>>> sv/eais_checker.sv
// Port-level checker for the event angle index search unit and its bind.
`timescale 1ns / 1ps

module eais_checker
    import eais_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_word  i_word,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("Stalled output word changed.");

    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.below_first |-> o_word.found_index == '0)
        else $error("Below-first result carries a nonzero index.");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_word.command == CMD_SEARCH |=> o_stall)
        else $error("Search word did not occupy the unit.");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_word.command == CMD_WRITE |=> !o_stall)
        else $error("Write word left the unit busy.");

endmodule

bind event_angle_index_search_unit eais_checker u_eais_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_word  (i_word),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);

>>> tb/testbench.sv
// Self-checking testbench for the event angle index search unit.
`timescale 1ns / 1ps

import eais_pkg::*;

class angle_search_scoreboard;
    bit [ANGLE_W-1:0] angles [TABLE_DEPTH];
    bit [CNT_W-1:0]   event_count;
    bit               rising_only;
    t_out_word        due_words [$];
    int               mismatches;

    function new();
        foreach (angles[i]) angles[i] = '0;
        event_count = 1;
        rising_only = 1'b0;
        mismatches  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        if (index == REG_EVENT_COUNT) begin
            event_count = data[CNT_W-1:0];
        end else if (index == REG_RISING_ONLY) begin
            rising_only = data[0];
        end
    endfunction

    function int span();
        if (event_count == 0) return 1;
        if (event_count > TABLE_DEPTH) return TABLE_DEPTH;
        return int'(event_count);
    endfunction

    function t_out_word last_at_or_below(bit [ANGLE_W-1:0] target);
        t_out_word r;
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = span() - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (angles[mid] <= target) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        if (lo == 0) begin
            r.found_index = '0;
            r.below_first = 1'b1;
        end else begin
            r.found_index = IDX_W'(lo - 1);
            if (rising_only) r.found_index[0] = 1'b0;
            r.below_first = 1'b0;
        end
        return r;
    endfunction

    function void note_word(t_in_word w);
        if (w.command == CMD_WRITE) begin
            angles[w.entry_index] = w.entry_angle;
        end else begin
            due_words.push_back(last_at_or_below(w.target_angle));
        end
    endfunction

    function void check_word(t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got index %0d below %0b",
                     $time, got.found_index, got.below_first);
            return;
        end
        want = due_words.pop_front();
        if (got.found_index !== want.found_index) begin
            mismatches++;
            $display("%0t: found_index expected %0d, got %0d",
                     $time, want.found_index, got.found_index);
        end
        if (got.below_first !== want.below_first) begin
            mismatches++;
            $display("%0t: below_first expected %0b, got %0b",
                     $time, want.below_first, got.below_first);
        end
    endfunction

    function int pending();
        return due_words.size();
    endfunction
endclass

module testbench;
    localparam int SETTLE_CYCLES      = 40;
    localparam int SEARCHES_PER_PHASE = 20;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    t_in_word              i_word      = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_word             o_word;

    angle_search_scoreboard sb;
    bit loaded [TABLE_DEPTH];
    int tx_streak = 0;
    int rx_streak = 0;
    bit tx_calm   = 1'b0;
    bit rx_calm   = 1'b0;

    always #1 i_clk = ~i_clk;

    event_angle_index_search_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

    function automatic int draw_wait(inout int streak, inout bit calm);
        if (streak == 0) begin
            streak = $urandom_range(8, 40);
            calm   = ($urandom_range(0, 2) == 0);
        end
        streak--;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic t_in_word write_word(int index, int angle);
        t_in_word w;
        w.command      = CMD_WRITE;
        w.entry_index  = index[IDX_W-1:0];
        w.entry_angle  = angle[ANGLE_W-1:0];
        w.target_angle = ANGLE_W'($urandom_range(0, 65535));
        return w;
    endfunction

    function automatic t_in_word search_word(int target);
        t_in_word w;
        w.command      = CMD_SEARCH;
        w.entry_index  = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        w.entry_angle  = ANGLE_W'($urandom_range(0, 65535));
        w.target_angle = target[ANGLE_W-1:0];
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = draw_wait(tx_streak, tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        if (w.command == CMD_WRITE) loaded[w.entry_index] = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(w);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(int count, bit rising);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_EVENT_COUNT;
        i_cfg_data  <= count[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.write_register(REG_EVENT_COUNT, count[CFG_DATA_W-1:0]);
        i_cfg_index <= REG_RISING_ONLY;
        i_cfg_data  <= CFG_DATA_W'(rising);
        @(posedge i_clk);
        sb.write_register(REG_RISING_ONLY, CFG_DATA_W'(rising));
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_table(int n);
        int angle;
        int lim;
        angle = $urandom_range(0, 3000);
        lim   = (2 * 46080) / n;
        if (lim < 1) lim = 1;
        for (int i = 0; i < n; i++) begin
            send_word(write_word(i, angle));
            if ($urandom_range(0, 3) != 0) angle += $urandom_range(1, lim);
            if (angle > 65535) angle = 65535;
        end
    endtask

    function automatic int pick_target(int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 65535);
            3: return (sb.angles[0] > 0) ? sb.angles[0] - 1 : 0;
            7: return (sb.angles[k] < 65535) ? sb.angles[k] + 1 : 65535;
            8: return (sb.angles[k] > 0) ? sb.angles[k] - 1 : 0;
            9: return $urandom_range(sb.angles[0], sb.angles[n - 1]);
            default: return sb.angles[k];
        endcase
    endfunction

    task automatic run_phase(int count, bit rising);
        int n;
        bit missing;
        set_config(count, rising);
        n = sb.span();
        missing = 1'b0;
        for (int i = 0; i < n; i++) if (!loaded[i]) missing = 1'b1;
        if (missing || (n <= 64 && $urandom_range(0, 2) == 0)) load_table(n);
        repeat (SEARCHES_PER_PHASE) begin
            if ($urandom_range(0, 7) == 0) begin
                send_word(write_word($urandom_range(0, TABLE_DEPTH - 1),
                                     $urandom_range(0, 65535)));
            end else begin
                send_word(search_word(pick_target(n)));
            end
        end
    endtask

    initial begin
        int counts [13] = '{3, 1, 0, 17, 512, 40, 1023, 2, 300, 511, 8, 513, 64};
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(1, 1'b0);
        send_word(write_word(0, 1000));
        send_word(search_word(999));
        send_word(search_word(1000));
        send_word(search_word(0));
        send_word(search_word(65535));

        set_config(4, 1'b1);
        send_word(write_word(1, 2000));
        send_word(write_word(2, 2000));
        send_word(write_word(3, 65535));
        send_word(search_word(2000));
        send_word(search_word(65535));
        send_word(search_word(1500));
        send_word(search_word(500));
        send_word(write_word(511, 0));
        send_word(write_word(511, 46080));

        set_config(0, 1'b0);
        send_word(search_word(999));
        send_word(search_word(1000));

        foreach (counts[k]) run_phase(counts[k], k % 2 == 1);

        drain();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(rx_streak, rx_calm);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_word(o_word);
        end
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule

>>> filelist.f
sv/eais_pkg.sv
sv/event_angle_index_search_unit.sv
sv/eais_checker.sv
tb/testbench.sv
